@@ hdl/srr_pkg.sv @@
package srr_pkg;

  localparam int PAYLOAD_W = 160;
  localparam int SEQ_W = 20;
  localparam int SUM_W = 24;
  localparam int ACHK_W = 22;

  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;
  localparam logic [1:0] KIND_CORRUPT = 2'd3;

  localparam logic [ACHK_W-1:0] ACK_BYTE_SUM = 22'd207;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic seq_ok;
    logic sum_ok;
    logic [PAYLOAD_W-1:0] payload;
  } pkt_t;

endpackage

@@ hdl/srr_front.sv @@
module srr_front #(
  parameter int SEQ_LIMIT = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [19:0] in_seq_num,
  input  logic [19:0] in_ack_num,
  input  logic signed [22:0] in_check_value,
  input  logic [srr_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic q_full,
  output logic q_push,
  output srr_pkg::pkt_t q_data
);
  import srr_pkg::*;

  localparam logic [SEQ_W:0] LIMIT_V = (SEQ_W+1)'(SEQ_LIMIT);

  logic f_valid_r;
  logic f_done_r;
  logic [1:0] f_grp_r;
  logic f_stop_r;
  logic signed [SUM_W-1:0] f_sum_r;
  logic [SEQ_W-1:0] f_seq_r;
  logic signed [22:0] f_chk_r;
  logic [PAYLOAD_W-1:0] f_pay_r;
  logic [39:0] grp;
  logic signed [SUM_W-1:0] f_sum_nxt;
  logic f_stop_nxt;

  assign q_push = f_valid_r && f_done_r && !q_full;
  assign in_ready = !f_valid_r || q_push;

  always_comb begin
    unique case (f_grp_r)
      2'd0: grp = f_pay_r[39:0];
      2'd1: grp = f_pay_r[79:40];
      2'd2: grp = f_pay_r[119:80];
      2'd3: grp = f_pay_r[159:120];
    endcase
  end

  always_comb begin
    logic [7:0] b;
    f_sum_nxt = f_sum_r;
    f_stop_nxt = f_stop_r;
    for (int i = 0; i < 5; i++) begin
      b = grp[i*8 +: 8];
      if (!f_stop_nxt) begin
        f_sum_nxt = f_sum_nxt + {{(SUM_W-8){b[7]}}, b};
        if (b == 8'd0) begin
          f_stop_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_data.seq = f_seq_r;
    q_data.seq_ok = {1'b0, f_seq_r} < LIMIT_V;
    q_data.sum_ok = f_sum_r == {f_chk_r[22], f_chk_r};
    q_data.payload = f_pay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      f_done_r <= 1'b0;
      f_grp_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        f_valid_r <= 1'b1;
        f_done_r <= 1'b0;
        f_grp_r <= '0;
        f_stop_r <= 1'b0;
        f_sum_r <= SUM_W'({4'd0, in_seq_num}) + SUM_W'({4'd0, in_ack_num});
        f_seq_r <= in_seq_num;
        f_chk_r <= in_check_value;
        f_pay_r <= in_payload;
      end else if (q_push) begin
        f_valid_r <= 1'b0;
      end else if (f_valid_r && !f_done_r) begin
        f_sum_r <= f_sum_nxt;
        f_stop_r <= f_stop_nxt;
        f_grp_r <= f_grp_r + 2'd1;
        if (f_grp_r == 2'd3) begin
          f_done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/srr_queue.sv @@
module srr_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  srr_pkg::pkt_t wr_data,
  input  logic pop,
  output srr_pkg::pkt_t rd_data,
  output logic full,
  output logic empty
);
  import srr_pkg::*;

  pkt_t q_mem_r [2];
  logic wr_ptr_r;
  logic rd_ptr_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rd_data = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_mem_r[wr_ptr_r] <= wr_data;
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

@@ hdl/srr_back.sv @@
module srr_back #(
  parameter int WINDOW = 8,
  parameter int SEQ_LIMIT = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  srr_pkg::pkt_t q_head,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_kind,
  output logic [19:0] out_seq,
  output logic [srr_pkg::ACHK_W-1:0] out_ack_check,
  output logic [srr_pkg::PAYLOAD_W-1:0] out_payload,
  output logic out_last
);
  import srr_pkg::*;

  localparam int EW = $clog2(SEQ_LIMIT + 1);
  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW1 = SW + 1;
  localparam int CW = SEQ_W + 2;
  localparam logic [CW-1:0] LIMIT_C = CW'(SEQ_LIMIT);
  localparam logic [CW-1:0] WIN_C = CW'(WINDOW);
  localparam logic [SW1-1:0] WIN_S = SW1'(WINDOW);
  localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_DLV,
    S_ACK
  } state_t;

  state_t state_r;
  pkt_t w_r;
  logic [EW-1:0] exp_r;
  logic [SW-1:0] slot_r;
  logic [WINDOW-1:0] flags_r;
  logic [PAYLOAD_W-1:0] store_mem [WINDOW];
  logic [PAYLOAD_W-1:0] rd_data_r;

  logic out_valid_r;
  logic [1:0] out_kind_r;
  logic [SEQ_W-1:0] out_seq_r;
  logic [ACHK_W-1:0] out_ack_check_r;
  logic [PAYLOAD_W-1:0] out_payload_r;
  logic out_last_r;

  logic can_load;
  logic res_load;
  logic [CW-1:0] seq_c;
  logic [CW-1:0] exp_c;
  logic drop;
  logic is_new;
  logic [SW1-1:0] slot_sum;
  logic [SW-1:0] new_slot;
  logic mem_we;
  logic mem_re;

  assign can_load = !out_valid_r || out_ready;
  assign res_load = can_load && ((state_r == S_DLV) || (state_r == S_ACK) ||
                    ((state_r == S_CHECK) && (drop || !w_r.sum_ok)));
  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign seq_c = CW'(w_r.seq);
  assign exp_c = CW'(exp_r);
  assign drop = (exp_c >= LIMIT_C) || !w_r.seq_ok || (seq_c >= exp_c + WIN_C);
  assign is_new = seq_c >= exp_c;
  assign slot_sum = SW1'(slot_r) + SW1'(seq_c - exp_c);
  assign new_slot = (slot_sum >= WIN_S) ? SW'(slot_sum - WIN_S) : SW'(slot_sum);
  assign mem_we = (state_r == S_CHECK) && !drop && w_r.sum_ok && is_new;
  assign mem_re = state_r == S_READ;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[new_slot] <= w_r.payload;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      exp_r <= '0;
      slot_r <= '0;
      flags_r <= '0;
    end else begin
      if (out_valid_r && out_ready && !res_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            w_r <= q_head;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (drop || !w_r.sum_ok) begin
            if (can_load) begin
              out_valid_r <= 1'b1;
              out_kind_r <= drop ? KIND_DROP : KIND_CORRUPT;
              out_seq_r <= '0;
              out_ack_check_r <= '0;
              out_payload_r <= '0;
              out_last_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else if (is_new) begin
            flags_r[new_slot] <= 1'b1;
            state_r <= S_READ;
          end else begin
            state_r <= S_ACK;
          end
        end
        S_READ: begin
          state_r <= flags_r[slot_r] ? S_DLV : S_ACK;
        end
        S_DLV: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_kind_r <= KIND_DELIVER;
            out_seq_r <= SEQ_W'(exp_r);
            out_ack_check_r <= '0;
            out_payload_r <= rd_data_r;
            out_last_r <= 1'b0;
            flags_r[slot_r] <= 1'b0;
            exp_r <= exp_r + EW'(1);
            slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + SW'(1);
            state_r <= S_READ;
          end
        end
        S_ACK: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_kind_r <= KIND_ACK;
            out_seq_r <= w_r.seq;
            out_ack_check_r <= {1'b0, w_r.seq, 1'b0} + ACK_BYTE_SUM;
            out_payload_r <= '0;
            out_last_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_seq = out_seq_r;
  assign out_ack_check = out_ack_check_r;
  assign out_payload = out_payload_r;
  assign out_last = out_last_r;

endmodule

@@ hdl/selective_repeat_receiver_top.sv @@
// Selective-repeat receiver. Each input item is one data packet: sequence, ack,
// carried checksum and a 20-byte payload split over three words. Each packet
// gives one or more result items, and the final one has out_last set. A bad
// packet gives a single drop or corrupt status. A good new packet is buffered
// and releases every in-order payload as deliver items, followed by an ACK.
// An old duplicate gives only an ACK.
// The front registers a packet and sums its payload five bytes per cycle, so it
// takes a new item only once it has pushed the last one, and hands the packet
// on through a two-entry queue; up to three packets may wait while the back
// works or the result channel stalls.
// For a new packet the back checks it, then reads and delivers each in-order
// payload in turn and sends the ACK; an old duplicate goes from the check to
// the ACK and a bad packet gives its status at the check. The payload store
// has one read port, so the payloads are read one at a time.
// A stalled result channel holds the pending result and pauses the back.
// Reset clears the expected sequence and all slot flags; the payload store
// is not cleared, since a slot's data is delivered only after it has been written.
module selective_repeat_receiver_top #(
  parameter int WINDOW = 8,
  parameter int SEQ_LIMIT = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [19:0] in_seq_num,
  input  logic [19:0] in_ack_num,
  input  logic signed [22:0] in_check_value,
  input  logic [63:0] in_payload_low,
  input  logic [63:0] in_payload_mid,
  input  logic [31:0] in_payload_high,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_kind,
  output logic [19:0] out_seq,
  output logic [21:0] out_ack_check,
  output logic [63:0] out_low,
  output logic [63:0] out_mid,
  output logic [31:0] out_high,
  output logic out_last
);
  import srr_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  pkt_t q_wr;
  pkt_t q_head;
  logic [PAYLOAD_W-1:0] out_payload;

  srr_front #(
    .SEQ_LIMIT(SEQ_LIMIT)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_seq_num(in_seq_num),
    .in_ack_num(in_ack_num),
    .in_check_value(in_check_value),
    .in_payload({in_payload_high, in_payload_mid, in_payload_low}),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_wr)
  );

  srr_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .wr_data(q_wr),
    .pop(q_pop),
    .rd_data(q_head),
    .full(q_full),
    .empty(q_empty)
  );

  srr_back #(
    .WINDOW(WINDOW),
    .SEQ_LIMIT(SEQ_LIMIT)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_empty(q_empty),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_seq(out_seq),
    .out_ack_check(out_ack_check),
    .out_payload(out_payload),
    .out_last(out_last)
  );

  assign out_low = out_payload[63:0];
  assign out_mid = out_payload[127:64];
  assign out_high = out_payload[159:128];

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue pushed while full");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind != KIND_DELIVER)))
    else $error("last flag does not match result kind");

  a_check_only_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_ACK) |-> (out_ack_check == '0))
    else $error("ack checksum set on a non-ACK result");

endmodule
